[rtl/grid_path_walker_macros.svh]
// Assertion macros shared by the grid path walker RTL.
`ifndef GRID_PATH_WALKER_MACROS_SVH
`define GRID_PATH_WALKER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define GPW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("grid_path_walker: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define GPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("grid_path_walker: next-cycle check failed");

`endif

[rtl/gpw_pkg.sv]
// Shared types, mode codes and helpers of the grid path walker.
`default_nettype none

package gpw_pkg;

    localparam int GRID_DEFAULT = 16;

    localparam logic [2:0] MODE_L_LONG  = 3'd0;
    localparam logic [2:0] MODE_L_SHORT = 3'd1;
    localparam logic [2:0] MODE_L_LEFT  = 3'd2;
    localparam logic [2:0] MODE_DIAG    = 3'd3;
    localparam logic [2:0] MODE_STAIR   = 3'd4;

    localparam logic [5:0] STAMP_FIRST = 6'd11;
    localparam logic [5:0] STAMP_MAX   = 6'd41;

    typedef struct packed {
        logic [2:0] mode;
        logic       rows_first;
    } t_step_ctl;

    function automatic logic [3:0] abs_diff(input logic [3:0] a, input logic [3:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

[rtl/gpw_step.sv]
// Step unit: moves the walk one cell toward the center for the active mode.
`default_nettype none

module gpw_step
    import gpw_pkg::*;
(
    input  wire logic [3:0] i_cur_row,
    input  wire logic [3:0] i_cur_col,
    input  wire logic [3:0] i_goal_row,
    input  wire logic [3:0] i_goal_col,
    input  wire t_step_ctl  i_ctl,
    output logic      [3:0] o_next_row,
    output logic      [3:0] o_next_col,
    output logic            o_at_goal
);

    logic [3:0] adr;
    logic [3:0] adc;
    logic       row_nz;
    logic       col_nz;
    logic       mv_row;
    logic       mv_col;

    always_comb begin
        adr    = abs_diff(i_cur_row, i_goal_row);
        adc    = abs_diff(i_cur_col, i_goal_col);
        row_nz = (adr != 4'd0);
        col_nz = (adc != 4'd0);
        mv_row = 1'b0;
        mv_col = 1'b0;
        case (i_ctl.mode)
            MODE_DIAG: begin
                mv_row = (adr >= adc) && row_nz;
                mv_col = (adc >= adr) && col_nz;
            end
            MODE_STAIR: begin
                mv_row = row_nz;
                mv_col = col_nz;
            end
            MODE_L_LONG, MODE_L_SHORT, MODE_L_LEFT: begin
                if (i_ctl.rows_first) begin
                    mv_row = row_nz;
                    mv_col = !row_nz;
                end else begin
                    mv_col = col_nz;
                    mv_row = !col_nz;
                end
            end
            default: begin
                mv_row = row_nz;
                mv_col = !row_nz;
            end
        endcase

        o_next_row = i_cur_row;
        if (mv_row) begin
            o_next_row = (i_cur_row > i_goal_row) ? (i_cur_row - 4'd1) : (i_cur_row + 4'd1);
        end
        o_next_col = i_cur_col;
        if (mv_col) begin
            o_next_col = (i_cur_col > i_goal_col) ? (i_cur_col - 4'd1) : (i_cur_col + 4'd1);
        end
        o_at_goal = !row_nz && !col_nz;
    end

endmodule

`default_nettype wire

[rtl/grid_path_walker.sv]
// Top level of the grid path walker: request intake, walk sequencer, result stream.
`default_nettype none

// A request beat carries a mode in tuser and a center and a start cell in tdata.
// The block answers with one result beat per cell from the start to the center,
// the center last and marked by tlast, stamps counting up from 11. The walk
// sequencer moves one cell per cycle through a single step unit while the
// result side takes every beat, and back-pressure holds it on the current
// cell; a path has N = 1 to 31 cells. A request is taken only when the
// previous run has ended. A request with a mode above 4 is accepted and
// dropped with no result.
// Coordinates at or beyond GRID are clamped to GRID - 1.
module grid_path_walker
    import gpw_pkg::*;
#(
    parameter int GRID = GRID_DEFAULT
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // center_row[3:0], center_col[7:4], start_row[11:8], start_col[15:12]
    input  wire logic [15:0] i_s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // cell_row[3:0], cell_col[7:4], stamp[13:8], zero[15:14]
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

`include "grid_path_walker_macros.svh"

    localparam logic [3:0] COORD_MAX = (GRID > 16) ? 4'd15 : 4'(GRID - 1);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cur_row, n_cur_row;
    logic [3:0] r_cur_col, n_cur_col;
    logic [3:0] r_goal_row, n_goal_row;
    logic [3:0] r_goal_col, n_goal_col;
    t_step_ctl  r_ctl, n_ctl;
    logic [5:0] r_stamp, n_stamp;

    logic [3:0] in_cr, in_cc, in_sr, in_sc;
    logic [3:0] in_adr, in_adc;
    logic       in_rf;
    logic [3:0] step_row, step_col;
    logic       at_goal;

    function automatic logic [3:0] clamp_coord(input logic [3:0] v);
        clamp_coord = (int'(v) >= GRID) ? COORD_MAX : v;
    endfunction

    gpw_step u_step (
        .i_cur_row  (r_cur_row),
        .i_cur_col  (r_cur_col),
        .i_goal_row (r_goal_row),
        .i_goal_col (r_goal_col),
        .i_ctl      (r_ctl),
        .o_next_row (step_row),
        .o_next_col (step_col),
        .o_at_goal  (at_goal)
    );

    always_comb begin
        in_cr  = clamp_coord(i_s_axis_tdata[3:0]);
        in_cc  = clamp_coord(i_s_axis_tdata[7:4]);
        in_sr  = clamp_coord(i_s_axis_tdata[11:8]);
        in_sc  = clamp_coord(i_s_axis_tdata[15:12]);
        in_adr = abs_diff(in_sr, in_cr);
        in_adc = abs_diff(in_sc, in_cc);
        case (i_s_axis_tuser)
            MODE_L_LONG:  in_rf = in_adc < in_adr;
            MODE_L_SHORT: in_rf = (in_adc == 4'd0) || ((in_adr != 4'd0) && (in_adr < in_adc));
            MODE_L_LEFT:  in_rf = (in_adc == 4'd0) || ((in_sr < in_cr) && (in_sc < in_cc))
                                  || ((in_sr > in_cr) && (in_sc > in_cc));
            default:      in_rf = 1'b0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_goal_row = r_goal_row;
        n_goal_col = r_goal_col;
        n_ctl      = r_ctl;
        n_stamp    = r_stamp;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid && (i_s_axis_tuser <= MODE_STAIR)) begin
                    n_state         = ST_WALK;
                    n_cur_row       = in_sr;
                    n_cur_col       = in_sc;
                    n_goal_row      = in_cr;
                    n_goal_col      = in_cc;
                    n_ctl.mode       = i_s_axis_tuser;
                    n_ctl.rows_first = in_rf;
                    n_stamp         = STAMP_FIRST;
                end
            end
            ST_WALK: begin
                if (i_m_axis_tready) begin
                    if (at_goal) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cur_row = step_row;
                        n_cur_col = step_col;
                        n_stamp   = r_stamp + 6'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cur_row  <= n_cur_row;
        r_cur_col  <= n_cur_col;
        r_goal_row <= n_goal_row;
        r_goal_col <= n_goal_col;
        r_ctl      <= n_ctl;
        r_stamp    <= n_stamp;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_WALK);
    assign o_m_axis_tdata  = {2'b00, r_stamp, r_cur_col, r_cur_row};
    assign o_m_axis_tlast  = at_goal;

    `GPW_ASSERT_NOW(a_one_side_open, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready)
    `GPW_ASSERT_NEXT(a_stamp_advance, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast,
        o_m_axis_tvalid && (r_stamp == $past(r_stamp) + 6'd1))
    `GPW_ASSERT_NEXT(a_last_frees_input, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, o_s_axis_tready)
    `GPW_ASSERT_NOW(a_stamp_range, i_clk, i_rst_n, o_m_axis_tvalid,
        (r_stamp >= STAMP_FIRST) && (r_stamp <= STAMP_MAX))

endmodule

`default_nettype wire
